@@ sv/tspd_pkg.sv @@
// Package for the tablet serial packet decoder.
// Holds the frame constants, the result kind codes and the decoded packet type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tspd_pkg;

  localparam int unsigned FRAME_LEN   = 7;
  localparam int unsigned STORE_DEPTH = FRAME_LEN - 1;
  localparam int unsigned CNT_W       = $clog2(FRAME_LEN + 1);
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned PRESS_W = 8;
  localparam int unsigned BTN_W   = 3;
  localparam int unsigned OUT_W   = 48;

  localparam int unsigned HDR_BIT    = 7;
  localparam int unsigned STYLUS_BIT = 5;
  localparam int unsigned SIGN_BIT   = 6;

  typedef enum logic {
    KIND_AXIS = 1'b0,
    KIND_BTN  = 1'b1
  } kind_e;

  typedef struct packed {
    logic               btn_chg;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [PRESS_W-1:0] pressure;
    logic [BTN_W-1:0]   buttons;
  } pkt_t;

endpackage
`default_nettype wire

@@ sv/tspd_frame.sv @@
// Frame assembler: stores the incoming bytes, tracks the frame position and
// decodes a full stylus frame into a registered packet. Depends on tspd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tspd_frame (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        byte_valid_i,
  output logic                             byte_ready_o,
  input  wire logic [tspd_pkg::BYTE_W-1:0] byte_i,
  output logic                             pkt_valid_o,
  input  wire logic                        pkt_ready_i,
  output tspd_pkg::pkt_t                   pkt_o
);
  import tspd_pkg::*;

  logic [BYTE_W-1:0] store_q [STORE_DEPTH];
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_eff;
  logic [BTN_W-1:0]  prev_btn_q, prev_btn_d;
  logic              pkt_valid_q, pkt_valid_d;
  pkt_t              pkt_q, pkt_d;
  logic              accept, full_frame, decode;
  logic [BYTE_W-1:0] b0, b1, b2, b3, b4, b5, b6;

  assign byte_ready_o = !pkt_valid_q || pkt_ready_i || (cnt_q != CNT_W'(STORE_DEPTH));
  assign accept       = byte_valid_i && byte_ready_o;

  assign cnt_eff    = byte_i[HDR_BIT] ? '0 : cnt_q;
  assign full_frame = (cnt_eff == CNT_W'(STORE_DEPTH));

  assign b0 = store_q[0];
  assign b1 = store_q[1];
  assign b2 = store_q[2];
  assign b3 = store_q[3];
  assign b4 = store_q[4];
  assign b5 = store_q[5];
  assign b6 = byte_i;

  assign decode = accept && full_frame && b0[STYLUS_BIT];

  always_comb begin
    pkt_d.pos_x    = {b0[1:0], 14'd0} + {1'b0, b1, 7'd0} + {8'd0, b2};
    pkt_d.pos_y    = {b3[1:0], 14'd0} + {1'b0, b4, 7'd0} + {8'd0, b5};
    pkt_d.pressure = {~b6[SIGN_BIT], b6[5:0], b3[2]};
    pkt_d.buttons  = b3[5:3];
    pkt_d.btn_chg  = (b3[5:3] != prev_btn_q);
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept && cnt_eff < CNT_W'(FRAME_LEN)) begin
      cnt_d = cnt_eff + CNT_W'(1);
    end else if (accept) begin
      cnt_d = cnt_eff;
    end
  end

  assign prev_btn_d = decode ? pkt_d.buttons : prev_btn_q;

  always_comb begin
    pkt_valid_d = pkt_valid_q;
    if (decode) begin
      pkt_valid_d = 1'b1;
    end else if (pkt_ready_i) begin
      pkt_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      prev_btn_q  <= '0;
      pkt_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      prev_btn_q  <= prev_btn_d;
      pkt_valid_q <= pkt_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && cnt_eff < CNT_W'(STORE_DEPTH)) begin
      store_q[cnt_eff[IDX_W-1:0]] <= byte_i;
    end
    if (decode) begin
      pkt_q <= pkt_d;
    end
  end

  assign pkt_valid_o = pkt_valid_q;
  assign pkt_o       = pkt_q;

endmodule
`default_nettype wire

@@ sv/tspd_out.sv @@
// Result sequencer: holds one decoded packet and issues an optional button
// beat followed by the axis beat. Depends on tspd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tspd_out (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       pkt_valid_i,
  output logic                            pkt_ready_o,
  input  wire tspd_pkg::pkt_t             pkt_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [tspd_pkg::OUT_W-1:0]      out_data_o,
  output tspd_pkg::kind_e                 out_kind_o,
  output logic                            out_last_o
);
  import tspd_pkg::*;

  pkt_t pkt_q;
  logic btn_pend_q, btn_pend_d;
  logic axis_pend_q, axis_pend_d;
  logic take_in, beat_done;

  assign beat_done   = axis_pend_q && out_ready_i;
  assign pkt_ready_o = !axis_pend_q || (out_ready_i && !btn_pend_q);
  assign take_in     = pkt_valid_i && pkt_ready_o;

  always_comb begin
    btn_pend_d  = btn_pend_q;
    axis_pend_d = axis_pend_q;
    if (take_in) begin
      btn_pend_d  = pkt_i.btn_chg;
      axis_pend_d = 1'b1;
    end else if (beat_done && btn_pend_q) begin
      btn_pend_d = 1'b0;
    end else if (beat_done) begin
      axis_pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_pend_q  <= 1'b0;
      axis_pend_q <= 1'b0;
    end else begin
      btn_pend_q  <= btn_pend_d;
      axis_pend_q <= axis_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      pkt_q <= pkt_i;
    end
  end

  always_comb begin
    if (btn_pend_q) begin
      out_data_o = {5'd0, pkt_q.buttons, {PRESS_W{1'b0}}, {POS_W{1'b0}}, {POS_W{1'b0}}};
      out_kind_o = KIND_BTN;
    end else begin
      out_data_o = {5'd0, pkt_q.buttons, pkt_q.pressure, pkt_q.pos_y, pkt_q.pos_x};
      out_kind_o = KIND_AXIS;
    end
  end

  assign out_valid_o = axis_pend_q;
  assign out_last_o  = !btn_pend_q;

endmodule
`default_nettype wire

@@ sv/tablet_serial_packet_decoder.sv @@
// Top level of the tablet serial packet decoder: frame assembler followed by
// the result sequencer. Depends on tspd_pkg, tspd_frame and tspd_out.
//
// Usage: serial bytes enter on the slave stream, one byte per beat. A byte
// with bit 7 set starts a new seven-byte frame. When the seventh byte of a
// stylus frame is taken, a decoded report leaves on the master stream: a
// button beat (tuser high, tlast low) when the button bits changed, then an
// axis beat (tuser low, tlast high). Cursor frames and bytes beyond a full
// frame give no beat.
// Timing: the decoded packet is registered in the frame assembler, then
// taken into the result sequencer, whose registers drive the first beat.
// Throughput: one byte per cycle while s_axis_tready is high; a report has at
// most two beats, far fewer than the seven bytes of a frame, so the input
// never waits on a receiver that keeps tready high.
// A stalled receiver holds the current beat; one further decoded packet
// waits in the frame assembler while bytes keep flowing, and the input stalls
// when a further frame reaches its seventh byte while that packet still waits.
// Reset clears the frame position, the last button state and all pending
// beats; the byte store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module tablet_serial_packet_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [15:0] pos_x, [31:16] pos_y,
                                           // [39:32] pressure, [42:40] button_bits
  output logic             m_axis_tuser,   // [0] kind
  output logic             m_axis_tlast
);
  import tspd_pkg::*;

  logic  pkt_valid, pkt_ready;
  pkt_t  pkt;
  kind_e out_kind;

  tspd_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .pkt_valid_o  (pkt_valid),
    .pkt_ready_i  (pkt_ready),
    .pkt_o        (pkt)
  );

  tspd_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_valid_i (pkt_valid),
    .pkt_ready_o (pkt_ready),
    .pkt_i       (pkt),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (out_kind),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = out_kind;

  a_btn_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_kind == KIND_BTN) |-> !m_axis_tlast)
    else $error("Button beat marked as last.");

  a_axis_follows_btn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && out_kind == KIND_BTN)
      |=> (m_axis_tvalid && out_kind == KIND_AXIS))
    else $error("Axis beat did not follow a button beat.");

  a_pkt_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pkt_valid && !pkt_ready) |=> (pkt_valid && $stable(pkt)))
    else $error("Pending packet lost or changed.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (pkt_valid && m_axis_tvalid))
    else $error("Input stalled without pending packets.");

endmodule
`default_nettype wire
